@@ sv/dllm_pkg.sv @@
// ============================================================================
// dllm_pkg: shared types and codes for the linked list manager
// Request and result formats, operation and status codes, node store
// access structs and the sequencer states.
// ============================================================================
`default_nettype none

package dllm_pkg;

  localparam int IDX_W    = 6;
  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 2;

  typedef logic [IDX_W-1:0] dllm_idx_t;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_PREPEND   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP_FIRST = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_POP_LAST  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE    = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_IS_EMPTY  = 3'd5;

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    dllm_idx_t         list_id;
    dllm_idx_t         node_id;
  } dllm_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    dllm_idx_t           node_out;
    logic                is_empty;
  } dllm_rsp_t;

  // One read address shared by both stores, one write port on each.
  typedef struct packed {
    logic      rd_en;
    dllm_idx_t rd_addr;
    logic      nx_we;
    dllm_idx_t nx_addr;
    dllm_idx_t nx_data;
    logic      pv_we;
    dllm_idx_t pv_addr;
    dllm_idx_t pv_data;
  } dllm_mem_req_t;

  typedef struct packed {
    dllm_idx_t nx;
    dllm_idx_t pv;
  } dllm_mem_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_NODE,
    ST_INS2,
    ST_DONE
  } dllm_state_e;

endpackage

`default_nettype wire

@@ sv/dllm_store.sv @@
// ============================================================================
// dllm_store: next and prev index memories
// Two synchronous memories with one write port each and a common read
// address; read data is registered and valid in the cycle after the request.
// ============================================================================
`default_nettype none

module dllm_store #(
  parameter int NODES = 64
) (
  input  logic                   clk_i,
  input  dllm_pkg::dllm_mem_req_t req_i,
  output dllm_pkg::dllm_mem_rsp_t rsp_o
);
  import dllm_pkg::*;

  localparam int DEPTH = (NODES < (1 << IDX_W)) ? NODES : (1 << IDX_W);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SIZE  = 1 << AW;

  dllm_idx_t next_mem [SIZE];
  dllm_idx_t prev_mem [SIZE];
  dllm_idx_t nx_rd_q;
  dllm_idx_t pv_rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.nx_we) begin
      next_mem[AW'(req_i.nx_addr)] <= req_i.nx_data;
    end
    if (req_i.rd_en) begin
      nx_rd_q <= next_mem[AW'(req_i.rd_addr)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.pv_we) begin
      prev_mem[AW'(req_i.pv_addr)] <= req_i.pv_data;
    end
    if (req_i.rd_en) begin
      pv_rd_q <= prev_mem[AW'(req_i.rd_addr)];
    end
  end

  assign rsp_o.nx = nx_rd_q;
  assign rsp_o.pv = pv_rd_q;

endmodule

`default_nettype wire

@@ sv/doubly_linked_list_manager.sv @@
// ============================================================================
// doubly_linked_list_manager: circular doubly linked lists over a node pool
// Each request prepends, appends, pops from either end, removes a node or
// tests a list for empty, and returns one result transaction.
// ============================================================================
//
//  Channel  Dir  Handshake                Payload
//  -------  ---  -----------------------  ------------------------------------
//  in       in   in_valid_i / in_stall_o  in_data_i  (func, list_id, node_id)
//  out      out  out_valid_o / out_stall_i out_data_o (status, node_out,
//                                                      is_empty)
//
//  A successful insert, a pop from a non-empty list and the removal of a
//  linked node go from the head step through ST_NODE or ST_INS2 to ST_DONE;
//  every other request (is-empty, rejected inserts, empty pops, removal of an
//  unlinked node, unused codes, out-of-range requests) goes straight from the
//  head step to ST_DONE, as set by the single read port of each index
//  memory: the head entry is read first, then the target node, then the
//  writes land. Reset clears the linked flags at once (flip-flops); the
//  index memories are not cleared, and an entry is only used once linked.
//  A result waits in the output register while out_stall_i is high; the next
//  request is still accepted and worked on, and only its final step waits.
//
`default_nettype none

module doubly_linked_list_manager #(
  parameter int NODES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dllm_pkg::dllm_req_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dllm_pkg::dllm_rsp_t out_data_o
);
  import dllm_pkg::*;

  // Only the first 2**IDX_W nodes can ever be named by a request.
  localparam int DEPTH = (NODES < (1 << IDX_W)) ? NODES : (1 << IDX_W);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SIZE  = 1 << AW;

  dllm_state_e   state_q, state_d;
  dllm_req_t     req_q, req_d;
  dllm_rsp_t     res_q, res_d;
  dllm_idx_t     nh_q, nh_d;
  dllm_idx_t     before_q, before_d;
  dllm_idx_t     after_q, after_d;
  dllm_idx_t     tgt_q, tgt_d;
  logic [SIZE-1:0] linked_q, linked_d;
  logic          out_valid_q, out_valid_d;
  dllm_rsp_t     out_data_q, out_data_d;

  dllm_mem_req_t mem_req;
  dllm_mem_rsp_t mem_rsp;

  logic          in_accept;
  logic          out_free;
  logic [AW-1:0] h_a, n_a, t_a;
  logic          lh, ln;
  logic          h_ok, n_ok;
  logic          is_ins, is_pop, is_rem;
  logic          head_empty;
  dllm_idx_t     new_nh;

  dllm_store #(
    .NODES(NODES)
  ) u_store (
    .clk_i(clk_i),
    .req_i(mem_req),
    .rsp_o(mem_rsp)
  );

  // The output register frees up in the same cycle the consumer takes it.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) || ((state_q == ST_DONE) && out_free));
  assign in_accept  = in_valid_i && !in_stall_o;

  assign h_a = AW'(req_q.list_id);
  assign n_a = AW'(req_q.node_id);
  assign t_a = AW'(tgt_q);
  assign lh  = linked_q[h_a];
  assign ln  = linked_q[n_a];

  assign h_ok = 32'(req_q.list_id) < NODES;
  assign n_ok = 32'(req_q.node_id) < NODES;

  assign is_ins = (req_q.func == FUNC_PREPEND) || (req_q.func == FUNC_APPEND);
  assign is_pop = (req_q.func == FUNC_POP_FIRST) || (req_q.func == FUNC_POP_LAST);
  assign is_rem = (req_q.func == FUNC_REMOVE);

  // An unlinked head is an empty self-loop. Valid while the head's entry is
  // on the read data, which is the case in the head step.
  assign head_empty = !lh || (mem_rsp.nx == req_q.list_id);

  // After a splice, the head's next moves only when the spliced node was
  // the head's direct successor.
  assign new_nh = (mem_rsp.pv == req_q.list_id) ? mem_rsp.nx : nh_q;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    res_d       = res_q;
    nh_d        = nh_q;
    before_d    = before_q;
    after_d     = after_q;
    tgt_d       = tgt_q;
    linked_d    = linked_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    mem_req     = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
      end

      // Head entry is on the read data: decide the operation.
      ST_HEAD: begin
        nh_d           = mem_rsp.nx;
        state_d        = ST_DONE;
        res_d.status   = STATUS_DONE;
        res_d.node_out = '0;
        res_d.is_empty = head_empty;
        if (!h_ok || ((is_ins || is_rem) && !n_ok)) begin
          res_d.is_empty = 1'b1;
        end else if (is_ins) begin
          if ((req_q.node_id == req_q.list_id) || ln) begin
            res_d.status = STATUS_REJECT;
          end else begin
            if (req_q.func == FUNC_PREPEND) begin
              before_d = req_q.list_id;
              after_d  = lh ? mem_rsp.nx : req_q.list_id;
            end else begin
              before_d = lh ? mem_rsp.pv : req_q.list_id;
              after_d  = req_q.list_id;
            end
            mem_req.nx_we   = 1'b1;
            mem_req.nx_addr = before_d;
            mem_req.nx_data = req_q.node_id;
            mem_req.pv_we   = 1'b1;
            mem_req.pv_addr = after_d;
            mem_req.pv_data = req_q.node_id;
            res_d.is_empty  = 1'b0;
            state_d         = ST_INS2;
          end
        end else if (is_pop) begin
          if (head_empty) begin
            res_d.status = STATUS_EMPTY;
          end else begin
            tgt_d           = (req_q.func == FUNC_POP_FIRST) ? mem_rsp.nx : mem_rsp.pv;
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = tgt_d;
            state_d         = ST_NODE;
          end
        end else if (is_rem && ln) begin
          tgt_d           = req_q.node_id;
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = tgt_d;
          state_d         = ST_NODE;
        end
      end

      // Target entry is on the read data: splice it out of its ring.
      ST_NODE: begin
        mem_req.pv_we   = 1'b1;
        mem_req.pv_addr = mem_rsp.nx;
        mem_req.pv_data = mem_rsp.pv;
        mem_req.nx_we   = 1'b1;
        mem_req.nx_addr = mem_rsp.pv;
        mem_req.nx_data = mem_rsp.nx;
        linked_d[t_a]   = 1'b0;
        res_d.node_out  = is_pop ? tgt_q : '0;
        if ((tgt_q == req_q.list_id) || !lh) begin
          res_d.is_empty = 1'b1;
        end else begin
          res_d.is_empty = (new_nh == req_q.list_id);
        end
        state_d = ST_DONE;
      end

      // Second half of an insert: the new node's own links.
      ST_INS2: begin
        mem_req.nx_we   = 1'b1;
        mem_req.nx_addr = req_q.node_id;
        mem_req.nx_data = after_q;
        mem_req.pv_we   = 1'b1;
        mem_req.pv_addr = req_q.node_id;
        mem_req.pv_data = before_q;
        linked_d[n_a]   = 1'b1;
        linked_d[h_a]   = 1'b1;
        state_d         = ST_DONE;
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A new request starts with a read of its head entry.
    if (in_accept) begin
      req_d           = in_data_i;
      mem_req.rd_en   = 1'b1;
      mem_req.rd_addr = in_data_i.list_id;
      state_d         = ST_HEAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      linked_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      linked_q    <= linked_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    res_q      <= res_d;
    nh_q       <= nh_d;
    before_q   <= before_d;
    after_q    <= after_d;
    tgt_q      <= tgt_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A node is only spliced out when it is linked.
  a_node_linked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NODE) |-> linked_q[t_a])
    else $error("splice of an unlinked node");

  // Finishing an insert leaves both the node and its head linked.
  a_ins_links: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INS2) |=> (linked_q[n_a] && linked_q[h_a]))
    else $error("insert did not link node and head");

  // The index memories are never written while no request is in flight.
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!mem_req.nx_we && !mem_req.pv_we))
    else $error("index write while idle");

  // Only a completed pop can report a node.
  a_status_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status != STATUS_DONE)) |-> (out_data_o.node_out == '0))
    else $error("node reported with a failure status");

endmodule

`default_nettype wire
